// ----- design/assert_macros.svh -----
// Assertion macros included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// Condition must never be true.
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// ----- design/evr_pkg.sv -----
// Package with types, constants and arithmetic helpers for the Euler rotation block.
package evr_pkg;

  // Angle format: 65536 units per turn, cut to the top ANGLE_BITS bits.
  localparam int ANGLE_W    = 16;
  localparam int ANGLE_BITS = 16;
  localparam logic [ANGLE_W-1:0] ANGLE_MASK =
    ~((ANGLE_W'(1) << (ANGLE_W - ANGLE_BITS)) - ANGLE_W'(1));
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  // Folded quarter angle, 0 to 16384.
  localparam int U_W = 15;
  localparam logic [U_W-1:0] QUARTER_U = 15'd16384;

  // Series constants in unsigned Q30.
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int SERIES_N = 6;

  // Vector and trig formats.
  localparam int VEC_W  = 32;
  localparam int TRIG_W = 18;
  localparam int FRAC_W = 16;
  localparam int PROD_W = TRIG_W + VEC_W;
  localparam int RND_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = RND_W + 1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h8000);
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

  // Pipeline depths.
  localparam int SINE_LAT  = 23;
  localparam int TURN_LAT  = 2;
  localparam int TOTAL_LAT = SINE_LAT + 3 * TURN_LAT;

  // Rotation planes.
  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;
  localparam logic [1:0] PLANE_ZX = 2'd2;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [TRIG_W-1:0] sin_v;
    logic [TRIG_W-1:0] cos_v;
  } trig_t;

  // Divisors of the nested sine series, innermost first.
  function automatic logic [7:0] series_div(input int idx);
    logic [7:0] d;
    case (idx)
      0:       d = 8'd156;
      1:       d = 8'd110;
      2:       d = 8'd72;
      3:       d = 8'd42;
      4:       d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // Round a Q2.16 times Q15.16 product to Q15.16, halves toward plus infinity.
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + $signed(ROUND_HALF);
    return t[PROD_W-1:FRAC_W];
  endfunction

  // Saturate a sum to a signed vector component.
  function automatic logic [VEC_W-1:0] sat_vec(input logic signed [SUM_W-1:0] v);
    logic [VEC_W-1:0] r;
    if ((&v[SUM_W-1:VEC_W-1]) || !(|v[SUM_W-1:VEC_W-1])) begin
      r = v[VEC_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(VEC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VEC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/evr_sine.sv -----
// Pipelined sine of a 16-bit angle in signed Q2.16, one word per cycle.
module evr_sine import evr_pkg::*; (
  input  logic                     clk,
  input  logic [ANGLE_W-1:0]       angle,
  output logic signed [TRIG_W-1:0] sine
);

  localparam int XP_W = U_W + 31;

  // Stage 1: fold the quadrant onto a quarter angle.
  logic [U_W-1:0] u_s1;
  logic           neg_s1;

  always_ff @(posedge clk) begin
    if (angle[14]) begin
      u_s1 <= QUARTER_U - {1'b0, angle[13:0]};
    end else begin
      u_s1 <= {1'b0, angle[13:0]};
    end
    neg_s1 <= angle[15];
  end

  // Stage 2: scale the quarter angle to radians in Q30.
  logic [XP_W-1:0] xprod;
  logic [30:0]     x_s2;
  logic            neg_s2;

  assign xprod = XP_W'(u_s1) * XP_W'(HALF_PI_Q30) + XP_W'(8192);

  always_ff @(posedge clk) begin
    x_s2   <= xprod[44:14];
    neg_s2 <= neg_s1;
  end

  // Stage 3: square of the argument.
  logic [61:0] xsq;
  logic [31:0] x2_s3;
  logic [30:0] x_s3;
  logic        neg_s3;

  assign xsq = 62'(x_s2) * 62'(x_s2);

  always_ff @(posedge clk) begin
    x2_s3  <= xsq[61:30];
    x_s3   <= x_s2;
    neg_s3 <= neg_s2;
  end

  // Series terms: each step is multiply, divide by reciprocal, then correct.
  logic [30:0] t_chain   [SERIES_N+1];
  logic [31:0] x2_chain  [SERIES_N+1];
  logic [30:0] x_chain   [SERIES_N+1];
  logic        neg_chain [SERIES_N+1];

  assign t_chain[0]   = Q30_ONE[30:0];
  assign x2_chain[0]  = x2_s3;
  assign x_chain[0]   = x_s3;
  assign neg_chain[0] = neg_s3;

  for (genvar i = 0; i < SERIES_N; i++) begin : g_term
    localparam logic [7:0]  DIV   = series_div(i);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DIV));

    logic [62:0] vprod;
    logic [31:0] v_a;
    logic [31:0] x2_a;
    logic [30:0] x_a;
    logic        neg_a;

    logic [63:0] mprod;
    logic [31:0] q0_b;
    logic [31:0] v_b;
    logic [31:0] x2_b;
    logic [30:0] x_b;
    logic        neg_b;

    logic [39:0] rem;
    logic [31:0] qc;
    logic [31:0] tw;
    logic [30:0] t_c;
    logic [31:0] x2_c;
    logic [30:0] x_c;
    logic        neg_c;

    // Product of the squared argument and the running term.
    assign vprod = 63'(x2_chain[i]) * 63'(t_chain[i]);

    always_ff @(posedge clk) begin
      v_a   <= vprod[61:30];
      x2_a  <= x2_chain[i];
      x_a   <= x_chain[i];
      neg_a <= neg_chain[i];
    end

    // Quotient estimate by reciprocal, low by at most one.
    assign mprod = 64'(v_a) * 64'(RECIP);

    always_ff @(posedge clk) begin
      q0_b  <= mprod[63:32];
      v_b   <= v_a;
      x2_b  <= x2_a;
      x_b   <= x_a;
      neg_b <= neg_a;
    end

    // Correct the quotient and form the next term.
    assign rem = 40'(v_b) - 40'(q0_b) * 40'(DIV);
    assign qc  = q0_b + 32'(rem >= 40'(DIV));
    assign tw  = Q30_ONE - qc;

    always_ff @(posedge clk) begin
      t_c   <= tw[30:0];
      x2_c  <= x2_b;
      x_c   <= x_b;
      neg_c <= neg_b;
    end

    assign t_chain[i+1]   = t_c;
    assign x2_chain[i+1]  = x2_c;
    assign x_chain[i+1]   = x_c;
    assign neg_chain[i+1] = neg_c;
  end

  // Final product with the argument.
  logic [61:0] yprod;
  logic [31:0] y_f;
  logic        neg_f;

  assign yprod = 62'(x_chain[SERIES_N]) * 62'(t_chain[SERIES_N]);

  always_ff @(posedge clk) begin
    y_f   <= yprod[61:30];
    neg_f <= neg_chain[SERIES_N];
  end

  // Round Q30 down to Q2.16 and apply the quadrant sign.
  logic [31:0]              ys;
  logic signed [TRIG_W-1:0] mag;

  assign ys  = y_f + 32'd8192;
  assign mag = $signed(ys[31:14]);

  always_ff @(posedge clk) begin
    if (neg_f) begin
      sine <= -mag;
    end else begin
      sine <= mag;
    end
  end

endmodule

// ----- design/evr_turn.sv -----
// One plane rotation of a vector: products, then rounding, sum and saturation.
module evr_turn import evr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  vec_t       in_vec,
  input  logic [1:0] plane,
  input  trig_t      trig,
  output logic       out_valid,
  output vec_t       out_vec
);

  // Pick the pair (a, b) that the plane turns.
  logic signed [VEC_W-1:0]  a;
  logic signed [VEC_W-1:0]  b;
  logic signed [TRIG_W-1:0] s;
  logic signed [TRIG_W-1:0] c;
  logic signed [TRIG_W-1:0] ns;

  always_comb begin
    case (plane)
      PLANE_XY: begin
        a = in_vec.x;
        b = in_vec.y;
      end
      PLANE_YZ: begin
        a = in_vec.y;
        b = in_vec.z;
      end
      PLANE_ZX: begin
        a = in_vec.z;
        b = in_vec.x;
      end
      default: begin
        a = in_vec.x;
        b = in_vec.y;
      end
    endcase
  end

  assign s  = trig.sin_v;
  assign c  = trig.cos_v;
  assign ns = -s;

  // Stage A: the four products.
  logic signed [PROD_W-1:0] p_ca;
  logic signed [PROD_W-1:0] p_sb;
  logic signed [PROD_W-1:0] p_nsa;
  logic signed [PROD_W-1:0] p_cb;
  vec_t                     vec_a;
  logic [1:0]               plane_a;
  logic                     valid_a;

  always_ff @(posedge clk) begin
    p_ca    <= PROD_W'(c) * PROD_W'(a);
    p_sb    <= PROD_W'(s) * PROD_W'(b);
    p_nsa   <= PROD_W'(ns) * PROD_W'(a);
    p_cb    <= PROD_W'(c) * PROD_W'(b);
    vec_a   <= in_vec;
    plane_a <= plane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
  end

  // Stage B: round each product, add pairs and saturate.
  logic [VEC_W-1:0] na;
  logic [VEC_W-1:0] nb;
  vec_t             vec_next;

  assign na = sat_vec(SUM_W'(round_q16(p_ca)) + SUM_W'(round_q16(p_sb)));
  assign nb = sat_vec(SUM_W'(round_q16(p_nsa)) + SUM_W'(round_q16(p_cb)));

  always_comb begin
    vec_next = vec_a;
    case (plane_a)
      PLANE_XY: begin
        vec_next.x = na;
        vec_next.y = nb;
      end
      PLANE_YZ: begin
        vec_next.y = na;
        vec_next.z = nb;
      end
      PLANE_ZX: begin
        vec_next.z = na;
        vec_next.x = nb;
      end
      default: begin
        vec_next = vec_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_vec <= vec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_a;
    end
  end

endmodule

// ----- design/euler_vector_rotation.sv -----
// Top level of the Euler-angle rotation of a fixed-point 3D vector.
//
//   Channel   Handshake        Payload
//   command   start / busy     vec_x, vec_y, vec_z, pitch_angle, roll_angle, yaw_angle, order
//   result    done (strobe)    out_x, out_y, out_z
//
// A word is taken on every cycle with start high; busy is held low.
// The word passes the sine series pipeline (six series steps of three stages
// each, around the argument and final products), then the three plane turns,
// each a product stage and a rounding stage. Throughput is one word per cycle.
// Reset clears only the valid bits; data registers are left as they are.
// The result is shown for exactly one cycle with done high and cannot be stalled.
`include "assert_macros.svh"

module euler_vector_rotation import evr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [VEC_W-1:0]    vec_x,
  input  logic [VEC_W-1:0]    vec_y,
  input  logic [VEC_W-1:0]    vec_z,
  input  logic [ANGLE_W-1:0]  pitch_angle,
  input  logic [ANGLE_W-1:0]  roll_angle,
  input  logic [ANGLE_W-1:0]  yaw_angle,
  input  logic                order,
  output logic                done,
  output logic [VEC_W-1:0]    out_x,
  output logic [VEC_W-1:0]    out_y,
  output logic [VEC_W-1:0]    out_z
);

  // The pipeline never stalls, so a command is always taken.
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Cut the angles and form the cosine angles.
  logic [ANGLE_W-1:0] pitch_cut;
  logic [ANGLE_W-1:0] roll_cut;
  logic [ANGLE_W-1:0] yaw_cut;

  assign pitch_cut = pitch_angle & ANGLE_MASK;
  assign roll_cut  = roll_angle & ANGLE_MASK;
  assign yaw_cut   = yaw_angle & ANGLE_MASK;

  // Six sine pipelines: sine and cosine for each angle.
  trig_t pitch_trig;
  trig_t roll_trig;
  trig_t yaw_trig;

  evr_sine u_pitch_sin (.clk(clk), .angle(pitch_cut), .sine(pitch_trig.sin_v));
  evr_sine u_pitch_cos (.clk(clk), .angle(pitch_cut + QUARTER_TURN), .sine(pitch_trig.cos_v));
  evr_sine u_roll_sin  (.clk(clk), .angle(roll_cut), .sine(roll_trig.sin_v));
  evr_sine u_roll_cos  (.clk(clk), .angle(roll_cut + QUARTER_TURN), .sine(roll_trig.cos_v));
  evr_sine u_yaw_sin   (.clk(clk), .angle(yaw_cut), .sine(yaw_trig.sin_v));
  evr_sine u_yaw_cos   (.clk(clk), .angle(yaw_cut + QUARTER_TURN), .sine(yaw_trig.cos_v));

  // Vector, order and valid travel alongside the sine pipelines.
  vec_t vec_d   [SINE_LAT];
  logic order_d [SINE_LAT];
  logic valid_d [SINE_LAT];

  always_ff @(posedge clk) begin
    vec_d[0]   <= '{x: vec_x, y: vec_y, z: vec_z};
    order_d[0] <= order;
    for (int k = 1; k < SINE_LAT; k++) begin
      vec_d[k]   <= vec_d[k-1];
      order_d[k] <= order_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SINE_LAT; k++) begin
        valid_d[k] <= 1'b0;
      end
    end else begin
      valid_d[0] <= accept;
      for (int k = 1; k < SINE_LAT; k++) begin
        valid_d[k] <= valid_d[k-1];
      end
    end
  end

  // Choose the first and last turns from the order bit.
  logic       ord_now;
  trig_t      trig1;
  trig_t      trig3;
  logic [1:0] plane1;
  logic [1:0] plane3;

  assign ord_now = order_d[SINE_LAT-1];
  assign trig1   = ord_now ? roll_trig : yaw_trig;
  assign trig3   = ord_now ? yaw_trig : roll_trig;
  assign plane1  = ord_now ? PLANE_ZX : PLANE_XY;
  assign plane3  = ord_now ? PLANE_XY : PLANE_ZX;

  // Hold the later turns' sines until their word arrives.
  trig_t      pitch_d  [TURN_LAT];
  trig_t      trig3_d  [2*TURN_LAT];
  logic [1:0] plane3_d [2*TURN_LAT];

  always_ff @(posedge clk) begin
    pitch_d[0]  <= pitch_trig;
    trig3_d[0]  <= trig3;
    plane3_d[0] <= plane3;
    for (int k = 1; k < TURN_LAT; k++) begin
      pitch_d[k] <= pitch_d[k-1];
    end
    for (int k = 1; k < 2*TURN_LAT; k++) begin
      trig3_d[k]  <= trig3_d[k-1];
      plane3_d[k] <= plane3_d[k-1];
    end
  end

  // Three plane turns in a row.
  logic t1_valid;
  logic t2_valid;
  logic t3_valid;
  vec_t t1_vec;
  vec_t t2_vec;
  vec_t t3_vec;

  evr_turn u_turn1 (
    .clk(clk), .rst(rst),
    .in_valid(valid_d[SINE_LAT-1]), .in_vec(vec_d[SINE_LAT-1]),
    .plane(plane1), .trig(trig1),
    .out_valid(t1_valid), .out_vec(t1_vec)
  );

  evr_turn u_turn2 (
    .clk(clk), .rst(rst),
    .in_valid(t1_valid), .in_vec(t1_vec),
    .plane(PLANE_YZ), .trig(pitch_d[TURN_LAT-1]),
    .out_valid(t2_valid), .out_vec(t2_vec)
  );

  evr_turn u_turn3 (
    .clk(clk), .rst(rst),
    .in_valid(t2_valid), .in_vec(t2_vec),
    .plane(plane3_d[2*TURN_LAT-1]), .trig(trig3_d[2*TURN_LAT-1]),
    .out_valid(t3_valid), .out_vec(t3_vec)
  );

  // Result word straight from the last turn's registers.
  assign done  = t3_valid;
  assign out_x = t3_vec.x;
  assign out_y = t3_vec.y;
  assign out_z = t3_vec.z;

  // Every result strobe traces back to a command a fixed latency earlier.
  `ASSERT_IMPLIES(a_done_has_cmd, clk, rst, done, $past(start && !busy, TOTAL_LAT))
  // Yaw sine and pitch cosine stay within one in magnitude.
  `ASSERT_IMPLIES(a_yaw_sin_range, clk, rst, valid_d[SINE_LAT-1], ($signed(yaw_trig.sin_v) <= TRIG_ONE) && ($signed(yaw_trig.sin_v) >= -TRIG_ONE))
  `ASSERT_IMPLIES(a_pitch_cos_range, clk, rst, valid_d[SINE_LAT-1], ($signed(pitch_trig.cos_v) <= TRIG_ONE) && ($signed(pitch_trig.cos_v) >= -TRIG_ONE))

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the Euler-angle vector rotation block.
`timescale 1ns / 100ps

module tb;
  import evr_pkg::*;

  // Rotation sequence selected by the order input.
  localparam logic ORDER_YPR = 1'b0;
  localparam logic ORDER_RPY = 1'b1;

  // Angles, 65536 units per turn.
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 16'h2000;
  localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANGLE_TOP   = 16'hFFFF;

  // Vector components in Q15.16.
  localparam logic [VEC_W-1:0] VEC_MAX = 32'h7FFF_FFFF;
  localparam logic [VEC_W-1:0] VEC_MIN = 32'h8000_0000;
  localparam logic [VEC_W-1:0] VEC_ONE = 32'h0001_0000;

  localparam int RANDOM_WORDS = 800;
  localparam int PAUSE_AT     = 400;
  localparam int DRAIN_LIMIT  = 8 * TOTAL_LAT;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
  } rotated_t;

  // Predicts each rotated vector and matches it against the block's output.
  class rotation_scoreboard;
    localparam longint COMP_HI = 64'sd2147483647;
    localparam longint COMP_LO = -64'sd2147483648;

    rotated_t    awaited_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned extremes;

    // Sine in Q2.16 from a nested Taylor series over the folded quarter turn.
    function longint sine_of(logic [ANGLE_W-1:0] angle);
      longint unsigned u, x, x2, t;
      longint unsigned divs[6];
      longint v;
      int k;
      divs = '{156, 110, 72, 42, 20, 6};
      u = angle[14] ? 64'd16384 - angle[13:0] : 64'(angle[13:0]);
      x = (u * 64'd1686629713 + 64'd8192) >> 14;
      x2 = (x * x) >> 30;
      t = 64'h4000_0000;
      for (k = 0; k < 6; k++) begin
        t = 64'h4000_0000 - ((x2 * t) >> 30) / divs[k];
      end
      v = longint'((((x * t) >> 30) + 64'd8192) >> 14);
      return angle[15] ? -v : v;
    endfunction

    // Q2.16 times Q15.16, rounded to nearest with halves going up.
    function longint round_product(longint c, longint v);
      return (c * v + 64'sd32768) >>> 16;
    endfunction

    function longint clamp_comp(longint v);
      if (v > COMP_HI) return COMP_HI;
      if (v < COMP_LO) return COMP_LO;
      return v;
    endfunction

    // Turns the pair (a, b) by the angle, cut to the block's angle precision.
    function void turn_plane(inout longint a, inout longint b, input logic [ANGLE_W-1:0] angle);
      logic [ANGLE_W-1:0] p;
      longint s, c, na, nb;
      p = (angle >> (ANGLE_W - ANGLE_BITS)) << (ANGLE_W - ANGLE_BITS);
      s = sine_of(p);
      c = sine_of(p + QUARTER_TURN);
      na = round_product(c, a) + round_product(s, b);
      nb = round_product(-s, a) + round_product(c, b);
      a = clamp_comp(na);
      b = clamp_comp(nb);
    endfunction

    function rotated_t rotate(logic [VEC_W-1:0] x, y, z, logic [ANGLE_W-1:0] pitch, roll, yaw,
                              logic order);
      longint ax, ay, az;
      rotated_t r;
      ax = $signed(x);
      ay = $signed(y);
      az = $signed(z);
      if (order == ORDER_YPR) begin
        turn_plane(ax, ay, yaw);
        turn_plane(ay, az, pitch);
        turn_plane(az, ax, roll);
      end else begin
        turn_plane(az, ax, roll);
        turn_plane(ay, az, pitch);
        turn_plane(ax, ay, yaw);
      end
      r.x = 32'(ax);
      r.y = 32'(ay);
      r.z = 32'(az);
      return r;
    endfunction

    function void note_word(logic [VEC_W-1:0] x, y, z, logic [ANGLE_W-1:0] pitch, roll, yaw,
                            logic order);
      awaited_q.push_back(rotate(x, y, z, pitch, roll, yaw, order));
    endfunction

    function void check_result(logic [VEC_W-1:0] x, y, z);
      rotated_t want;
      if (awaited_q.size() == 0) begin
        if (mismatches < 10) $display("tb: result x=%h y=%h z=%h with no word waiting", x, y, z);
        mismatches++;
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (want.x inside {VEC_MAX, VEC_MIN} || want.y inside {VEC_MAX, VEC_MIN} ||
          want.z inside {VEC_MAX, VEC_MIN}) begin
        extremes++;
      end
      if (x !== want.x || y !== want.y || z !== want.z) begin
        if (mismatches < 10) begin
          $display("tb: result %0d mismatch: expected x=%h y=%h z=%h,", checked,
                   want.x, want.y, want.z, " got x=%h y=%h z=%h", x, y, z);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [VEC_W-1:0]   vec_x = '0;
  logic [VEC_W-1:0]   vec_y = '0;
  logic [VEC_W-1:0]   vec_z = '0;
  logic [ANGLE_W-1:0] pitch_angle = '0;
  logic [ANGLE_W-1:0] roll_angle = '0;
  logic [ANGLE_W-1:0] yaw_angle = '0;
  logic               order = ORDER_YPR;
  logic               done;
  logic [VEC_W-1:0]   out_x;
  logic [VEC_W-1:0]   out_y;
  logic [VEC_W-1:0]   out_z;

  rotation_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned rpy_words = 0;

  euler_vector_rotation u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .yaw_angle   (yaw_angle),
    .order       (order),
    .done        (done),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Every word taken by the block gets a predicted result.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_word(vec_x, vec_y, vec_z, pitch_angle, roll_angle, yaw_angle, order);
      if (order == ORDER_RPY) rpy_words <= rpy_words + 1;
    end
  end

  // Results are strobed by done and cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(out_x, out_y, out_z);
  end

  // Presents one word and holds it until the block takes it.
  task automatic send_word(input logic [VEC_W-1:0] x, y, z,
                           input logic [ANGLE_W-1:0] pitch, roll, yaw, input logic ord);
    vec_x       <= x;
    vec_y       <= y;
    vec_z       <= z;
    pitch_angle <= pitch;
    roll_angle  <= roll;
    yaw_angle   <= yaw;
    order       <= ord;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has come back or the drain limit runs out.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Full range, small values around zero, and values at the extremes.
  function automatic logic [VEC_W-1:0] pick_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      7:          return VEC_MAX;
      8:          return VEC_MIN;
      default:    return ($urandom_range(0, 1) ? VEC_MAX : VEC_MIN) ^ $urandom_range(0, 65535);
    endcase
  endfunction

  // Random angles, with extra weight on multiples of 45 degrees and near right angles.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 7)) * EIGHTH_TURN;
      1:       return 16'($urandom_range(0, 3)) * QUARTER_TURN + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int i;
    int unsigned directed;
    bit burst;
    burst = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words: identity, right angles, extremes and saturation.
    send_word('0, '0, '0, '0, '0, '0, ORDER_YPR);
    idle_gap(gap_length());
    send_word(VEC_MAX, VEC_MIN, VEC_ONE, '0, '0, '0, ORDER_RPY);
    idle_gap(gap_length());
    send_word(VEC_ONE, 2 * VEC_ONE, 3 * VEC_ONE, '0, '0, QUARTER_TURN, ORDER_YPR);
    send_word(VEC_ONE, 2 * VEC_ONE, 3 * VEC_ONE, QUARTER_TURN, '0, '0, ORDER_YPR);
    send_word(VEC_ONE, 2 * VEC_ONE, 3 * VEC_ONE, '0, QUARTER_TURN, '0, ORDER_RPY);
    send_word(VEC_ONE, -VEC_ONE, 3 * VEC_ONE, HALF_TURN, HALF_TURN, HALF_TURN, ORDER_YPR);
    send_word(VEC_ONE, -VEC_ONE, 3 * VEC_ONE, 16'hC000, 16'hC000, 16'hC000, ORDER_RPY);
    idle_gap(gap_length());
    // Turning the most negative component by half a turn overflows.
    send_word(VEC_MIN, VEC_MIN, VEC_MIN, '0, '0, HALF_TURN, ORDER_YPR);
    send_word(VEC_MIN, VEC_MIN, VEC_MIN, HALF_TURN, HALF_TURN, '0, ORDER_RPY);
    // At 45 degrees equal components add up past full scale.
    send_word(VEC_MAX, VEC_MAX, VEC_MAX, EIGHTH_TURN, EIGHTH_TURN, EIGHTH_TURN, ORDER_YPR);
    send_word(VEC_MIN, VEC_MIN, VEC_MIN, EIGHTH_TURN, EIGHTH_TURN, EIGHTH_TURN, ORDER_RPY);
    send_word(VEC_MAX, VEC_MIN, VEC_MAX, 16'hE000, 16'h6000, 16'hA000, ORDER_YPR);
    idle_gap(gap_length());
    send_word(VEC_MAX, VEC_MAX, VEC_MAX, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP, ORDER_YPR);
    send_word(VEC_MIN, VEC_MIN, VEC_MIN, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP, ORDER_RPY);
    send_word(VEC_ONE, VEC_ONE, VEC_ONE, 16'd1, 16'd1, 16'd1, ORDER_YPR);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
              ORDER_RPY);
    send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA, 16'h5555,
              ORDER_YPR);
    send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 16'h3FFF, 16'h4001, 16'h7FFF,
              ORDER_RPY);
    directed = words_sent;
    idle_gap(gap_length());

    // Random words, with stretches of back-to-back traffic.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      send_word(pick_component(), pick_component(), pick_component(),
                pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
      if (i == PAUSE_AT) begin
        wait_drained();
      end else if (!burst) begin
        idle_gap(gap_length());
      end
    end

    wait_drained();
    repeat (TOTAL_LAT + 8) @(posedge clk);

    $display("tb: %0d words sent (%0d directed, %0d in roll-pitch-yaw order)",
             words_sent, directed, rpy_words);
    $display("tb: %0d results checked, %0d with a full-scale component, %0d missing",
             sb.checked, sb.extremes, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
